### sv/assert_macros.svh
// Assertion macros for the ray/triangle intersect RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// Next-cycle implication, disabled while in reset.
`define RTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`endif

### sv/rti_pkg.sv
// Package for the ray/triangle intersect unit: widths, codes, types, constants.
package rti_pkg;

    localparam int COORD_W       = 32;
    localparam int DIR_W         = 16;
    localparam int TRI_SLOTS_DEF = 1024;
    localparam int DET_W         = 84;

    // request mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TEST = 1'b1;

    // |det| * 100000 < 2^46  <=>  |det| < this bound
    localparam logic [DET_W-1:0] DET_MIN = DET_W'(64'd703687442);

    typedef logic [2:0][COORD_W-1:0] t_vertex;
    typedef t_vertex [2:0]           t_tri;

    // test request as handed to the datapath
    typedef struct packed {
        logic [2:0][COORD_W-1:0] org;
        logic [2:0][DIR_W-1:0]   dir;
        logic                    inr;
    } t_ray;

endpackage

### sv/rti_req_if.sv
// Request channel interface: valid/ready plus load/test payload.
interface rti_req_if
    import rti_pkg::*;
#(
    parameter int SLOT_W = 12,
    parameter int TRI_W  = 10
);
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [SLOT_W-1:0]         vertex_slot;
    logic [TRI_W-1:0]          triangle_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;

    modport source (output valid, mode, vertex_slot, triangle_index,
                    coord_x, coord_y, coord_z, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, mode, vertex_slot, triangle_index,
                    coord_x, coord_y, coord_z, dir_x, dir_y, dir_z, output ready);
endinterface

### sv/rti_rsp_if.sv
// Result channel interface: valid/ready plus hit flag.
interface rti_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

### sv/ray_triangle_intersect_unit.sv
// Ray/triangle intersect unit: vertex store plus Moller-Trumbore test pipeline.
//
// Usage:
//   i_req carries requests. mode LOAD writes coord_x/y/z as corner
//   (vertex_slot mod 3) of triangle (vertex_slot / 3); slots past the store
//   are ignored. mode TEST reads the three corners of triangle_index and
//   tests the ray (origin coord_*, direction dir_*) against it.
//   o_rsp returns one hit flag per TEST request, in request order; LOAD
//   requests give no result. Out-of-range triangles return hit 0.
// Timing:
//   One request per cycle is accepted while i_req.ready is high. A test result
//   shows on o_rsp after its request has passed every stage: the corner memory
//   read runs beside stage one, then edge, cross product, pvec/qvec, sliced
//   dot product, recombine, sum, sign, reject and compare stages. A test may
//   follow a load of its own corner at once.
// Reset:
//   Reset empties the pipeline; the store itself is not cleared, and a
//   corner must be loaded before any test reads it.
// Backpressure:
//   When o_rsp is held, results wait in the output stage and the pipeline
//   keeps accepting until all ten stages are full; only then i_req.ready drops.
module ray_triangle_intersect_unit
    import rti_pkg::*;
#(
    parameter int TRIANGLE_SLOTS = TRI_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rti_req_if.sink      i_req,
    rti_rsp_if.source    o_rsp
);

    localparam int SLOT_W = $clog2(3 * TRIANGLE_SLOTS);
    localparam int TRI_W  = (TRIANGLE_SLOTS > 1) ? $clog2(TRIANGLE_SLOTS) : 1;
    localparam logic [TRI_W:0] TRI_LIM = (TRI_W+1)'(TRIANGLE_SLOTS);

    logic    accept;
    logic    dp_ready;
    t_ray    ray;
    t_vertex wr_data;
    t_tri    corner;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = dp_ready;

    assign wr_data = {i_req.coord_z, i_req.coord_y, i_req.coord_x};

    // test request bundle
    assign ray.org = {i_req.coord_z, i_req.coord_y, i_req.coord_x};
    assign ray.dir = {i_req.dir_z, i_req.dir_y, i_req.dir_x};
    assign ray.inr = ({1'b0, i_req.triangle_index} < TRI_LIM);

    rti_vertex_store #(
        .TRIANGLE_SLOTS (TRIANGLE_SLOTS),
        .SLOT_W         (SLOT_W),
        .TRI_W          (TRI_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && i_req.mode == MODE_LOAD),
        .i_wr_slot (i_req.vertex_slot),
        .i_wr_data (wr_data),
        .i_rd_en   (dp_ready),
        .i_rd_tri  (i_req.triangle_index),
        .o_rd_data (corner)
    );

    rti_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray_valid (accept && i_req.mode == MODE_TEST),
        .i_ray       (ray),
        .i_corner    (corner),
        .o_ready     (dp_ready),
        .o_hit_valid (o_rsp.valid),
        .o_hit       (o_rsp.hit),
        .i_hit_ready (o_rsp.ready)
    );

endmodule

### sv/rti_vertex_store.sv
// Vertex store: one synchronous memory bank per triangle corner.
module rti_vertex_store
    import rti_pkg::*;
#(
    parameter int TRIANGLE_SLOTS = TRI_SLOTS_DEF,
    parameter int SLOT_W         = 12,
    parameter int TRI_W          = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_slot,
    input  t_vertex           i_wr_data,
    input  logic              i_rd_en,
    input  logic [TRI_W-1:0]  i_rd_tri,
    output t_tri              o_rd_data
);

    // slot / 3 by reciprocal multiply, exact for every slot value
    localparam int DIV_S = SLOT_W + 2;
    localparam int PRD_W = SLOT_W + DIV_S;
    localparam logic [DIV_S-1:0] DIV_M = DIV_S'(((1 << DIV_S) + 2) / 3);
    localparam logic [SLOT_W:0]  SLOT_LIM = (SLOT_W+1)'(3 * TRIANGLE_SLOTS);

    logic [PRD_W-1:0]  prod;
    logic [SLOT_W-1:0] quot;
    logic [SLOT_W+1:0] quot3;
    logic [1:0]        corner;
    logic              wr_ok;

    assign prod   = PRD_W'(i_wr_slot) * PRD_W'(DIV_M);
    assign quot   = prod[PRD_W-1:DIV_S];
    assign quot3  = (SLOT_W+2)'(quot) * (SLOT_W+2)'(3);
    assign corner = 2'((SLOT_W+2)'(i_wr_slot) - quot3);
    assign wr_ok  = i_wr_en && ({1'b0, i_wr_slot} < SLOT_LIM);

    // one bank per corner, read at the triangle index
    for (genvar c = 0; c < 3; c++) begin : g_bank
        t_vertex mem [TRIANGLE_SLOTS];
        t_vertex r_rd;

        always_ff @(posedge i_clk) begin
            if (wr_ok && corner == 2'(c)) begin
                mem[quot[TRI_W-1:0]] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= mem[i_rd_tri];
            end
        end

        assign o_rd_data[c] = r_rd;
    end

endmodule

### sv/rti_datapath.sv
// Intersect datapath: ten-stage Moller-Trumbore pipeline with per-stage flow control.
module rti_datapath
    import rti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ray_valid,
    input  t_ray i_ray,
    input  t_tri i_corner,
    output logic o_ready,
    output logic o_hit_valid,
    output logic o_hit,
    input  logic i_hit_ready
);
`include "assert_macros.svh"

    localparam int NSTG = 10;
    localparam int EW   = COORD_W + 1;       // edge width
    localparam int PW   = 50;                // pvec
    localparam int QW   = 67;                // qvec
    localparam int TW   = 101;               // T
    localparam int SW   = 117;               // 25000 * T

    logic [NSTG:1] r_vld;
    logic [NSTG:1] rdy;

    // flow control: a stage loads when empty or when the next one moves
    always_comb begin
        rdy[NSTG] = !r_vld[NSTG] || i_hit_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_ray_valid;
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_ready     = rdy[1];
    assign o_hit_valid = r_vld[NSTG];

    // stage 1: ray beside the registered corner data
    logic signed [COORD_W-1:0] r1_org [3];
    logic signed [DIR_W-1:0]   r1_dir [3];
    logic                      r1_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r1_org[i] <= $signed(i_ray.org[i]);
                r1_dir[i] <= $signed(i_ray.dir[i]);
            end
            r1_inr <= i_ray.inr;
        end
    end

    // stage 2: edges and origin offset
    logic signed [EW-1:0]    r2_ab [3], r2_ac [3], r2_tv [3];
    logic signed [DIR_W-1:0] r2_dir [3];
    logic                    r2_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_ab[i]  <= EW'($signed(i_corner[1][i])) - EW'($signed(i_corner[0][i]));
                r2_ac[i]  <= EW'($signed(i_corner[2][i])) - EW'($signed(i_corner[0][i]));
                r2_tv[i]  <= EW'(r1_org[i]) - EW'($signed(i_corner[0][i]));
                r2_dir[i] <= r1_dir[i];
            end
            r2_inr <= r1_inr;
        end
    end

    // stage 3: cross-product terms
    logic signed [48:0]      r3_pa [3], r3_pb [3];
    logic signed [65:0]      r3_qa [3], r3_qb [3];
    logic signed [EW-1:0]    r3_ab [3], r3_ac [3], r3_tv [3];
    logic signed [DIR_W-1:0] r3_dir [3];
    logic                    r3_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                r3_pa[i]  <= 49'(r2_dir[(i+1)%3]) * 49'(r2_ac[(i+2)%3]);
                r3_pb[i]  <= 49'(r2_dir[(i+2)%3]) * 49'(r2_ac[(i+1)%3]);
                r3_qa[i]  <= 66'(r2_tv[(i+1)%3]) * 66'(r2_ab[(i+2)%3]);
                r3_qb[i]  <= 66'(r2_tv[(i+2)%3]) * 66'(r2_ab[(i+1)%3]);
                r3_ab[i]  <= r2_ab[i];
                r3_ac[i]  <= r2_ac[i];
                r3_tv[i]  <= r2_tv[i];
                r3_dir[i] <= r2_dir[i];
            end
            r3_inr <= r2_inr;
        end
    end

    // stage 4: pvec and qvec
    logic signed [PW-1:0]    r4_pv [3];
    logic signed [QW-1:0]    r4_qv [3];
    logic signed [EW-1:0]    r4_ab [3], r4_ac [3], r4_tv [3];
    logic signed [DIR_W-1:0] r4_dir [3];
    logic                    r4_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            for (int i = 0; i < 3; i++) begin
                r4_pv[i]  <= PW'(r3_pa[i]) - PW'(r3_pb[i]);
                r4_qv[i]  <= QW'(r3_qa[i]) - QW'(r3_qb[i]);
                r4_ab[i]  <= r3_ab[i];
                r4_ac[i]  <= r3_ac[i];
                r4_tv[i]  <= r3_tv[i];
                r4_dir[i] <= r3_dir[i];
            end
            r4_inr <= r3_inr;
        end
    end

    // stage 5: dot-product partials, pvec in two slices, qvec in three
    logic signed [25:0] pv_lo [3];
    logic signed [24:0] pv_hi [3];
    logic signed [22:0] qv_lo [3], qv_md [3], qv_hi [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pv_lo[i] = $signed({1'b0, r4_pv[i][24:0]});
            pv_hi[i] = $signed(r4_pv[i][49:25]);
            qv_lo[i] = $signed({1'b0, r4_qv[i][21:0]});
            qv_md[i] = $signed({1'b0, r4_qv[i][43:22]});
            qv_hi[i] = $signed(r4_qv[i][66:44]);
        end
    end

    logic signed [58:0] r5_dl [3], r5_ul [3];
    logic signed [57:0] r5_dh [3], r5_uh [3];
    logic signed [38:0] r5_vl [3], r5_vm [3], r5_vh [3];
    logic signed [55:0] r5_tl [3], r5_tm [3], r5_th [3];
    logic               r5_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int i = 0; i < 3; i++) begin
                r5_dl[i] <= 59'(r4_ab[i]) * 59'(pv_lo[i]);
                r5_dh[i] <= 58'(r4_ab[i]) * 58'(pv_hi[i]);
                r5_ul[i] <= 59'(r4_tv[i]) * 59'(pv_lo[i]);
                r5_uh[i] <= 58'(r4_tv[i]) * 58'(pv_hi[i]);
                r5_vl[i] <= 39'(r4_dir[i]) * 39'(qv_lo[i]);
                r5_vm[i] <= 39'(r4_dir[i]) * 39'(qv_md[i]);
                r5_vh[i] <= 39'(r4_dir[i]) * 39'(qv_hi[i]);
                r5_tl[i] <= 56'(r4_ac[i]) * 56'(qv_lo[i]);
                r5_tm[i] <= 56'(r4_ac[i]) * 56'(qv_md[i]);
                r5_th[i] <= 56'(r4_ac[i]) * 56'(qv_hi[i]);
            end
            r5_inr <= r4_inr;
        end
    end

    // stage 6: recombine slices per component
    logic signed [DET_W-1:0] r6_d [3], r6_u [3], r6_v [3];
    logic signed [TW-1:0]    r6_t [3];
    logic                    r6_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            for (int i = 0; i < 3; i++) begin
                r6_d[i] <= (DET_W'(r5_dh[i]) <<< 25) + DET_W'(r5_dl[i]);
                r6_u[i] <= (DET_W'(r5_uh[i]) <<< 25) + DET_W'(r5_ul[i]);
                r6_v[i] <= (DET_W'(r5_vh[i]) <<< 44) + (DET_W'(r5_vm[i]) <<< 22)
                         + DET_W'(r5_vl[i]);
                r6_t[i] <= (TW'(r5_th[i]) <<< 44) + (TW'(r5_tm[i]) <<< 22)
                         + TW'(r5_tl[i]);
            end
            r6_inr <= r5_inr;
        end
    end

    // stage 7: det, U, V, T
    logic signed [DET_W-1:0] r7_det, r7_u, r7_v;
    logic signed [TW-1:0]    r7_t;
    logic                    r7_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r7_det <= r6_d[0] + r6_d[1] + r6_d[2];
            r7_u   <= r6_u[0] + r6_u[1] + r6_u[2];
            r7_v   <= r6_v[0] + r6_v[1] + r6_v[2];
            r7_t   <= r6_t[0] + r6_t[1] + r6_t[2];
            r7_inr <= r6_inr;
        end
    end

    // stage 8: fold the sign of det into all four
    logic signed [DET_W-1:0] r8_det, r8_u, r8_v;
    logic signed [TW-1:0]    r8_t;
    logic                    r8_inr;
    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            if (r7_det[DET_W-1]) begin
                r8_det <= -r7_det;
                r8_u   <= -r7_u;
                r8_v   <= -r7_v;
                r8_t   <= -r7_t;
            end else begin
                r8_det <= r7_det;
                r8_u   <= r7_u;
                r8_v   <= r7_v;
                r8_t   <= r7_t;
            end
            r8_inr <= r7_inr;
        end
    end

    // stage 9: early reject flags, u+v, 25000*T as two shift-add halves
    logic signed [DET_W:0]   r9_uv, r9_det;
    logic signed [SW-1:0]    r9_ta, r9_tb;
    logic                    r9_fail;
    always_ff @(posedge i_clk) begin
        if (rdy[9]) begin
            r9_fail <= !r8_inr
                    || (r8_det < $signed(DET_MIN))
                    || r8_u[DET_W-1] || (r8_u > r8_det)
                    || r8_v[DET_W-1];
            r9_uv  <= (DET_W+1)'(r8_u) + (DET_W+1)'(r8_v);
            r9_det <= (DET_W+1)'(r8_det);
            r9_ta  <= (SW'(r8_t) <<< 14) + (SW'(r8_t) <<< 13) + (SW'(r8_t) <<< 8);
            r9_tb  <= (SW'(r8_t) <<< 7) + (SW'(r8_t) <<< 5) + (SW'(r8_t) <<< 3);
        end
    end

    // stage 10: final compare into the output register
    logic r_hit;
    always_ff @(posedge i_clk) begin
        if (rdy[10]) begin
            r_hit <= !r9_fail && !(r9_uv > r9_det)
                  && ((r9_ta + r9_tb) > SW'(r9_det));
        end
    end

    assign o_hit = r_hit;

    // input stalls only when the whole pipe is full and the output is held
    `RTI_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !rdy[1], (&r_vld) && !i_hit_ready)
    // an accepted test request always lands in stage 1
    `RTI_ASSERT_NXT(a_enter, i_clk, i_rst_n, i_ray_valid, r_vld[1])
    // a request moving into the last stage is never dropped
    `RTI_ASSERT_NXT(a_last_move, i_clk, i_rst_n, r_vld[NSTG-1] && rdy[NSTG], r_vld[NSTG])

endmodule
